// File: sv/itf_pkg.sv
// shared constants and types of the ide task-file controller
`default_nettype none
package itf_pkg;

  // transaction kinds on the input channel
  typedef enum logic [2:0] {
    OP_BUS_WR   = 3'd0,
    OP_BUS_RD   = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_FILL     = 3'd3,
    OP_FETCH    = 3'd4
  } op_e;

  // task-file register offsets
  localparam logic [3:0] REG_DATA    = 4'h0;
  localparam logic [3:0] REG_ERROR   = 4'h1;
  localparam logic [3:0] REG_SCOUNT  = 4'h2;
  localparam logic [3:0] REG_SNUM    = 4'h3;
  localparam logic [3:0] REG_CYL_LO  = 4'h4;
  localparam logic [3:0] REG_CYL_HI  = 4'h5;
  localparam logic [3:0] REG_HEAD    = 4'h6;
  localparam logic [3:0] REG_COMMAND = 4'h7;
  localparam logic [3:0] REG_HIGH    = 4'h8;

  // ata command codes
  localparam logic [7:0] CMD_RESTORE  = 8'h10;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_VERIFY   = 8'h40;
  localparam logic [7:0] CMD_FORMAT   = 8'h50;
  localparam logic [7:0] CMD_SEEK     = 8'h70;
  localparam logic [7:0] CMD_SETPARAM = 8'h91;
  localparam logic [7:0] CMD_PIDENT   = 8'hA1;
  localparam logic [7:0] CMD_IDLE     = 8'hE3;
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

  // status and error values
  localparam logic [7:0] STS_READY = 8'h40;
  localparam logic [7:0] STS_BUSY  = 8'h80;
  localparam logic [7:0] STS_DRQ   = 8'h08;
  localparam logic [7:0] STS_ABORT = 8'h41;
  localparam logic [7:0] ERR_ABORT = 8'h04;
  localparam logic [7:0] RD_ABSENT = 8'hFC;
  localparam logic [7:0] RD_UNUSED = 8'hFF;

  // disk request codes
  localparam logic [1:0] DOP_NONE   = 2'd0;
  localparam logic [1:0] DOP_READ   = 2'd1;
  localparam logic [1:0] DOP_WRITE  = 2'd2;
  localparam logic [1:0] DOP_FORMAT = 2'd3;

  // busy delays
  localparam logic [9:0] DLY_NONE  = 10'd0;
  localparam logic [9:0] DLY_FLUSH = 10'd1000;
  localparam logic [9:0] DLY_CMD   = 10'd200;
  localparam logic [9:0] DLY_SEEK  = 10'd100;

  localparam logic [16:0] TOTAL_SECTORS = 17'd101808;

endpackage
`default_nettype wire

// File: sv/itf_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none
module itf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/ide_task_file_controller.sv
// ide task-file controller: registers, sector buffer, command sequencer
// One transaction in, one result transaction out. A simple register access,
// buffer fill or completion without a disk request goes from accept through
// the execute state to the finish state; buffer reads (data port, high-byte
// port, media fetch) add a read-wait state because the buffer ram read is
// registered. Completions of read, write and format pass through the multiply
// states, as the linear block index goes twice through the one shared 21x8
// multiplier (cylinder*heads+head, then *sectors). Identify does one multiply
// for sectors*heads, runs a restoring divider for the cylinder count, then a
// sweep that writes every buffer word. The input stall stays high from accept
// until the result is loaded into the output register. The 512-byte buffer is
// two 256x8 rams (even and odd byte lanes) with one valid bit per word, so
// reset and the clearing done by read and format completions clear only the
// valid bits, not the rams; a word that is not valid reads as zero.
`default_nettype none
module ide_task_file_controller import itf_pkg::*; #(
  parameter int INDEX_PERIOD = 199
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [3:0]  reg_addr_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  buffer_index_i,
  input  wire logic [7:0]  media_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic [1:0]       disk_op_o,
  output logic [27:0]      disk_block_o,
  output logic             disk_drive_o,
  output logic [7:0]       disk_count_o,
  output logic [9:0]       delay_request_o,
  output logic             bad_command_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_RDWAIT, ST_MUL1, ST_MUL2,
    ST_IDMUL, ST_DIV, ST_SWEEP, ST_FIN
  } state_e;

  localparam logic [7:0] IndexPeriod = 8'(INDEX_PERIOD);

  // identify data word for buffer word w
  function automatic logic [15:0] ident_word(input logic [7:0] w, input logic [7:0] spt,
                                             input logic [4:0] hpc, input logic [15:0] q);
    logic [15:0] v;
    v = 16'h0000;
    if ((w >= 8'd10 && w <= 8'd19) || (w >= 8'd23 && w <= 8'd46)) begin
      v = 16'h2020;
    end
    case (w)
      8'd1:    v = 16'd101;
      8'd3:    v = 16'd16;
      8'd6:    v = 16'd63;
      8'd23:   v = 16'h7632;
      8'd24:   v = 16'h2E31;
      8'd27:   v = 16'h422D;
      8'd28:   v = 16'h656D;
      8'd29:   v = 16'h2048;
      8'd30:   v = 16'h4420;
      8'd50:   v = 16'h4000;
      8'd53:   v = 16'd1;
      8'd54:   v = q;
      8'd55:   v = {11'd0, hpc};
      8'd56:   v = {8'd0, spt};
      8'd57:   v = TOTAL_SECTORS[15:0];
      8'd58:   v = {15'd0, TOTAL_SECTORS[16]};
      default: v = v;
    endcase
    return v;
  endfunction

  state_e state_q;
  logic   enable_q;

  // captured transaction
  logic [2:0] cmd_q;
  logic [3:0] addr_q;
  logic [7:0] wd_q, bi_q, mb_q;

  // task file
  logic [7:0]  status_q, error_q, scount_q, snum_q, precomp_q, command_q;
  logic [15:0] cyl_q;
  logic [3:0]  head_q;
  logic        drv_q;
  logic [7:0]  bp_w_q;   // data port position, word index (byte position is twice this)
  logic [7:0]  hw_q;     // high-byte port position, word index
  logic [7:0]  spt_q;
  logic [4:0]  hpc_q;
  logic [7:0]  icnt_q;

  // buffer bookkeeping
  logic [255:0] row_vld_q;
  logic         rd_vld_q, hi_lane_q;

  // shared multiplier and divider state
  logic        sec_term_q;
  logic [20:0] t_q;
  logic [12:0] prod_q, rem_q;
  logic [15:0] quo_q;
  logic [4:0]  div_cnt_q;
  logic [7:0]  sw_q;

  // result under construction
  logic [7:0]  r_rd_q, r_cnt_q;
  logic [1:0]  r_op_q;
  logic [27:0] r_blk_q;
  logic        r_drv_q, r_bad_q;
  logic [9:0]  r_dly_q;
  logic        out_valid_q;

  // ram ports
  logic       lo_we, hi_we;
  logic [7:0] waddr, lo_wdata, hi_wdata, lo_raddr, lo_rdata, hi_rdata;

  // multiplier operands
  logic [20:0] mul_a;
  logic [7:0]  mul_b;
  logic [28:0] mul_p;

  // sector/head/cylinder advance
  logic [7:0]  sn_inc, adv_sn, sc_dec;
  logic [4:0]  h_inc;
  logic [3:0]  adv_head;
  logic [15:0] adv_cyl;

  // divider step
  logic [13:0] trial;
  logic [15:0] ident_q16;
  logic [15:0] ident_val;

  logic accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    sn_inc   = snum_q + 8'd1;
    sc_dec   = scount_q - 8'd1;
    h_inc    = {1'b0, head_q} + 5'd1;
    adv_sn   = sn_inc;
    adv_head = head_q;
    adv_cyl  = cyl_q;
    // end of track: back to sector one, next head, maybe next cylinder
    if ({1'b0, sn_inc} == ({1'b0, spt_q} + 9'd1)) begin
      adv_sn = 8'd1;
      if (h_inc == hpc_q) begin
        adv_head = 4'd0;
        adv_cyl  = cyl_q + 16'd1;
      end else begin
        adv_head = h_inc[3:0];
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_MUL1: begin
        mul_a = {5'd0, cyl_q};
        mul_b = {3'd0, hpc_q};
      end
      ST_MUL2: begin
        mul_a = t_q;
        mul_b = spt_q;
      end
      default: begin
        mul_a = {13'd0, spt_q};
        mul_b = {3'd0, hpc_q};
      end
    endcase
    mul_p = 29'(mul_a * mul_b);
  end

  assign trial     = {rem_q, TOTAL_SECTORS[div_cnt_q]};
  assign ident_q16 = (prod_q == 13'd0) ? 16'd0 : quo_q;
  assign ident_val = ident_word(sw_q, spt_q, hpc_q, ident_q16);

  // buffer write control; a byte written into a cleared word zeroes its partner lane
  always_comb begin
    lo_we    = 1'b0;
    hi_we    = 1'b0;
    waddr    = bp_w_q;
    lo_wdata = wd_q;
    hi_wdata = 8'h00;
    lo_raddr = (cmd_q == OP_FETCH) ? bi_q : bp_w_q;
    if (state_q == ST_EXEC) begin
      case (cmd_q)
        OP_BUS_WR: begin
          if (enable_q && addr_q == REG_DATA) begin
            waddr = bp_w_q;
            lo_we = 1'b1;
            hi_we = !row_vld_q[bp_w_q];
          end else if (enable_q && addr_q == REG_HIGH) begin
            waddr    = hw_q;
            hi_we    = 1'b1;
            hi_wdata = wd_q;
            lo_we    = !row_vld_q[hw_q];
            lo_wdata = 8'h00;
          end
        end
        OP_FILL: begin
          waddr    = bi_q;
          lo_we    = 1'b1;
          lo_wdata = mb_q;
          hi_we    = !row_vld_q[bi_q];
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_SWEEP) begin
      waddr    = sw_q;
      lo_we    = 1'b1;
      hi_we    = 1'b1;
      lo_wdata = ident_val[7:0];
      hi_wdata = ident_val[15:8];
    end
  end

  itf_ram #(.Width(8), .Depth(256)) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (waddr),
    .wdata_i (lo_wdata),
    .raddr_i (lo_raddr),
    .rdata_o (lo_rdata)
  );

  itf_ram #(.Width(8), .Depth(256)) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (waddr),
    .wdata_i (hi_wdata),
    .raddr_i (hw_q),
    .rdata_o (hi_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enable_q    <= 1'b0;
      cmd_q       <= 3'd0;
      addr_q      <= 4'd0;
      wd_q        <= 8'd0;
      bi_q        <= 8'd0;
      mb_q        <= 8'd0;
      status_q    <= STS_READY;
      error_q     <= 8'd0;
      scount_q    <= 8'd1;
      snum_q      <= 8'd1;
      cyl_q       <= 16'd0;
      head_q      <= 4'd0;
      drv_q       <= 1'b0;
      precomp_q   <= 8'd0;
      command_q   <= 8'd0;
      bp_w_q      <= 8'd0;
      hw_q        <= 8'd0;
      spt_q       <= 8'd63;
      hpc_q       <= 5'd16;
      icnt_q      <= 8'd0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      hi_lane_q   <= 1'b0;
      sec_term_q  <= 1'b0;
      t_q         <= 21'd0;
      prod_q      <= 13'd0;
      rem_q       <= 13'd0;
      quo_q       <= 16'd0;
      div_cnt_q   <= 5'd0;
      sw_q        <= 8'd0;
      r_rd_q      <= 8'd0;
      r_op_q      <= DOP_NONE;
      r_blk_q     <= 28'd0;
      r_drv_q     <= 1'b0;
      r_cnt_q     <= 8'd0;
      r_dly_q     <= DLY_NONE;
      r_bad_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      read_data_o     <= 8'd0;
      disk_op_o       <= DOP_NONE;
      disk_block_o    <= 28'd0;
      disk_drive_o    <= 1'b0;
      disk_count_o    <= 8'd0;
      delay_request_o <= DLY_NONE;
      bad_command_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      // the finish state reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      if (lo_we || hi_we) begin
        row_vld_q[waddr] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            addr_q  <= reg_addr_i;
            wd_q    <= write_data_i;
            bi_q    <= buffer_index_i;
            mb_q    <= media_byte_i;
            r_rd_q  <= 8'd0;
            r_op_q  <= DOP_NONE;
            r_blk_q <= 28'd0;
            r_drv_q <= 1'b0;
            r_cnt_q <= 8'd0;
            r_dly_q <= DLY_NONE;
            r_bad_q <= 1'b0;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          state_q <= ST_FIN;
          case (cmd_q)
            OP_BUS_WR: begin
              if (enable_q) begin
                case (addr_q)
                  REG_DATA: begin
                    hw_q <= bp_w_q;
                    if (bp_w_q == 8'd255) begin
                      // last byte of the sector: flush to disk after a delay
                      bp_w_q   <= 8'd0;
                      status_q <= STS_BUSY;
                      r_dly_q  <= DLY_FLUSH;
                    end else begin
                      bp_w_q <= bp_w_q + 8'd1;
                    end
                  end
                  REG_ERROR:  precomp_q <= wd_q;
                  REG_SCOUNT: scount_q  <= wd_q;
                  REG_SNUM:   snum_q    <= wd_q;
                  REG_CYL_LO: cyl_q     <= {cyl_q[15:8], wd_q};
                  REG_CYL_HI: cyl_q     <= {wd_q, cyl_q[7:0]};
                  REG_HEAD: begin
                    head_q <= wd_q[3:0];
                    drv_q  <= wd_q[4];
                  end
                  REG_COMMAND: begin
                    command_q <= wd_q;
                    error_q   <= 8'd0;
                    case (wd_q)
                      CMD_RESTORE, CMD_SEEK: begin
                        status_q <= STS_READY;
                        r_dly_q  <= DLY_SEEK;
                      end
                      CMD_WRITE: begin
                        status_q <= STS_DRQ | STS_READY;
                        bp_w_q   <= 8'd0;
                      end
                      CMD_FORMAT: begin
                        status_q <= STS_DRQ;
                        bp_w_q   <= 8'd0;
                      end
                      CMD_READ, CMD_VERIFY, CMD_SETPARAM, CMD_PIDENT, CMD_IDLE,
                      CMD_IDENTIFY: begin
                        status_q <= STS_BUSY;
                        r_dly_q  <= DLY_CMD;
                      end
                      default: r_bad_q <= 1'b1;
                    endcase
                  end
                  default: begin
                  end
                endcase
              end
            end

            OP_BUS_RD: begin
              if (!enable_q) begin
                r_rd_q <= RD_ABSENT;
              end else begin
                case (addr_q)
                  REG_DATA: begin
                    rd_vld_q  <= row_vld_q[bp_w_q];
                    hi_lane_q <= 1'b0;
                    state_q   <= ST_RDWAIT;
                    hw_q      <= bp_w_q;
                    if (bp_w_q == 8'd255) begin
                      bp_w_q   <= 8'd0;
                      status_q <= STS_READY;
                      // multi-sector read: fetch the next sector
                      if (command_q == CMD_READ) begin
                        scount_q <= sc_dec;
                        if (sc_dec != 8'd0) begin
                          snum_q   <= adv_sn;
                          head_q   <= adv_head;
                          cyl_q    <= adv_cyl;
                          status_q <= STS_BUSY;
                          r_dly_q  <= DLY_CMD;
                        end
                      end
                    end else begin
                      bp_w_q <= bp_w_q + 8'd1;
                    end
                  end
                  REG_HIGH: begin
                    rd_vld_q  <= row_vld_q[hw_q];
                    hi_lane_q <= 1'b1;
                    state_q   <= ST_RDWAIT;
                  end
                  REG_ERROR:  r_rd_q <= error_q;
                  REG_SCOUNT: r_rd_q <= scount_q;
                  REG_SNUM:   r_rd_q <= snum_q;
                  REG_CYL_LO: r_rd_q <= cyl_q[7:0];
                  REG_CYL_HI: r_rd_q <= cyl_q[15:8];
                  REG_HEAD:   r_rd_q <= {3'd0, drv_q, head_q};
                  REG_COMMAND: begin
                    // index pulse shows in status bit 1 once per period
                    if (icnt_q + 8'd1 == IndexPeriod) begin
                      icnt_q <= 8'd0;
                      r_rd_q <= status_q | 8'h02;
                    end else begin
                      icnt_q <= icnt_q + 8'd1;
                      r_rd_q <= status_q;
                    end
                  end
                  default: r_rd_q <= RD_UNUSED;
                endcase
              end
            end

            OP_COMPLETE: begin
              case (command_q)
                CMD_RESTORE, CMD_SEEK: status_q <= STS_READY;
                CMD_READ: begin
                  r_op_q     <= DOP_READ;
                  r_drv_q    <= drv_q;
                  sec_term_q <= 1'b1;
                  row_vld_q  <= '0;
                  bp_w_q     <= 8'd0;
                  status_q   <= STS_DRQ | STS_READY;
                  state_q    <= ST_MUL1;
                end
                CMD_WRITE: begin
                  // block index uses the chs values from before count and chs advance
                  r_op_q     <= DOP_WRITE;
                  r_drv_q    <= drv_q;
                  sec_term_q <= 1'b1;
                  state_q    <= ST_MUL1;
                end
                CMD_VERIFY: begin
                  bp_w_q   <= 8'd0;
                  status_q <= STS_READY;
                end
                CMD_FORMAT: begin
                  r_op_q     <= DOP_FORMAT;
                  r_drv_q    <= drv_q;
                  r_cnt_q    <= scount_q;
                  sec_term_q <= 1'b0;
                  row_vld_q  <= '0;
                  status_q   <= STS_READY;
                  state_q    <= ST_MUL1;
                end
                CMD_SETPARAM: begin
                  spt_q    <= scount_q;
                  hpc_q    <= h_inc;
                  status_q <= STS_READY;
                end
                CMD_PIDENT, CMD_IDLE: begin
                  status_q <= STS_ABORT;
                  error_q  <= ERR_ABORT;
                end
                CMD_IDENTIFY: state_q <= ST_IDMUL;
                default: begin
                end
              endcase
            end

            OP_FETCH: begin
              rd_vld_q  <= row_vld_q[bi_q];
              hi_lane_q <= 1'b0;
              state_q   <= ST_RDWAIT;
            end

            default: begin
            end
          endcase
        end

        ST_RDWAIT: begin
          if (rd_vld_q) begin
            r_rd_q <= hi_lane_q ? hi_rdata : lo_rdata;
          end else begin
            r_rd_q <= 8'd0;
          end
          state_q <= ST_FIN;
        end

        ST_MUL1: begin
          t_q     <= mul_p[20:0] + {17'd0, head_q};
          state_q <= ST_MUL2;
        end

        ST_MUL2: begin
          r_blk_q <= mul_p[27:0] + (sec_term_q ? {20'd0, snum_q} : 28'd0);
          if (command_q == CMD_WRITE) begin
            scount_q <= sc_dec;
            if (sc_dec != 8'd0) begin
              status_q <= STS_DRQ | STS_READY;
              bp_w_q   <= 8'd0;
              snum_q   <= adv_sn;
              head_q   <= adv_head;
              cyl_q    <= adv_cyl;
            end else begin
              status_q <= STS_READY;
            end
          end
          state_q <= ST_FIN;
        end

        ST_IDMUL: begin
          prod_q    <= mul_p[12:0];
          rem_q     <= 13'd0;
          quo_q     <= 16'd0;
          div_cnt_q <= 5'd16;
          state_q   <= ST_DIV;
        end

        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (trial >= {1'b0, prod_q}) begin
            rem_q <= 13'(trial - {1'b0, prod_q});
            quo_q <= {quo_q[14:0], 1'b1};
          end else begin
            rem_q <= trial[12:0];
            quo_q <= {quo_q[14:0], 1'b0};
          end
          if (div_cnt_q == 5'd0) begin
            sw_q    <= 8'd0;
            state_q <= ST_SWEEP;
          end else begin
            div_cnt_q <= div_cnt_q - 5'd1;
          end
        end

        ST_SWEEP: begin
          if (sw_q == 8'd255) begin
            bp_w_q   <= 8'd0;
            status_q <= STS_DRQ;
            state_q  <= ST_FIN;
          end else begin
            sw_q <= sw_q + 8'd1;
          end
        end

        ST_FIN: begin
          // hand the result over once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q     <= 1'b1;
            read_data_o     <= r_rd_q;
            disk_op_o       <= r_op_q;
            disk_block_o    <= r_blk_q;
            disk_drive_o    <= r_drv_q;
            disk_count_o    <= r_cnt_q;
            delay_request_o <= r_dly_q;
            bad_command_o   <= r_bad_q;
            state_q         <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // a new result only appears when the sequencer finishes a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish");

  // an accepted transaction always starts execution next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted transaction not executed");

  // unsupported commands never issue a disk request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_command_o) |-> disk_op_o == DOP_NONE)
    else $error("disk request with bad command");

  // the divider counter counts down one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q != 5'd0) |=> div_cnt_q == $past(div_cnt_q) - 5'd1)
    else $error("divider step skipped");

  // the identify sweep ends in data-request status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sw_q == 8'd255) |=> status_q == STS_DRQ && bp_w_q == 8'd0)
    else $error("identify sweep end state wrong");

endmodule
`default_nettype wire
